[rtl/core/vr2d_pkg.sv]
// ----------------------------------------------------------------------------
// vr2d_pkg
// Shared constants, arctangent table and gain function for the 2D vector rotator.
// ----------------------------------------------------------------------------
package vr2d_pkg;

    // default sizes
    localparam int VR2D_DATA_WIDTH_DEF = 16;
    localparam int VR2D_ITERATIONS_DEF = 16;

    // fraction bits kept below the output lsb inside the datapath
    localparam int VR2D_GUARD = 8;
    // fraction bits of the gain constant
    localparam int VR2D_GAIN_FRAC = 30;
    // entries in the arctangent table, also the cap on the iteration count
    localparam int VR2D_ATAN_ENTRIES = 24;
    // angle accumulator width, units of 2^-32 turn plus headroom
    localparam int VR2D_ZW = 34;

    // gain compensation pieces, q30
    localparam logic [63:0] VR2D_K_INF_Q30        = 64'd652032874;
    localparam logic [63:0] VR2D_K_TWO_THIRDS_Q30 = 64'd434688583;

    // atan(2^-i) in 2^-32 turn units, rounded to nearest
    function automatic logic signed [VR2D_ZW-1:0] atan_turn(input int idx);
        logic signed [VR2D_ZW-1:0] val;
        case (idx)
            0:       val = 34'sd536870912;
            1:       val = 34'sd316933406;
            2:       val = 34'sd167458907;
            3:       val = 34'sd85004756;
            4:       val = 34'sd42667331;
            5:       val = 34'sd21354465;
            6:       val = 34'sd10679838;
            7:       val = 34'sd5340245;
            8:       val = 34'sd2670163;
            9:       val = 34'sd1335087;
            10:      val = 34'sd667544;
            11:      val = 34'sd333772;
            12:      val = 34'sd166886;
            13:      val = 34'sd83443;
            14:      val = 34'sd41722;
            15:      val = 34'sd20861;
            16:      val = 34'sd10430;
            17:      val = 34'sd5215;
            18:      val = 34'sd2608;
            19:      val = 34'sd1304;
            20:      val = 34'sd652;
            21:      val = 34'sd326;
            22:      val = 34'sd163;
            23:      val = 34'sd81;
            default: val = '0;
        endcase
        return val;
    endfunction

    // cordic gain compensation for n iterations, q30
    function automatic logic [31:0] gain_q30(input int n);
        logic [63:0] g;
        g = VR2D_K_INF_Q30 + (VR2D_K_TWO_THIRDS_Q30 >> (2 * n));
        return g[31:0];
    endfunction

endpackage

[rtl/core/vector_rotate_2d.sv]
// ----------------------------------------------------------------------------
// vector_rotate_2d
// Pipelined cordic rotator: turns (vec_x, vec_y) counterclockwise by angle.
//
// A transaction enters when start is high at a rising edge; busy stays low, so
// a new vector may enter every cycle. angle is a binary angle, 65536 = one turn.
// The result shows on rotated_x, rotated_y and saturated for one cycle with
// done high, taken at the edge ending that cycle; the receiver cannot stall.
// Between the accepting edge and the edge that takes the result lie three
// prescale stages (fold, gain multiply, round), one register per cordic
// cell and one output stage. Throughput is one per cycle.
// saturated flags a clipped component. Reset empties the pipeline; transactions
// in flight are dropped and done stays low until new ones come through.
// ----------------------------------------------------------------------------
module vector_rotate_2d #(
    parameter int ITERATIONS = vr2d_pkg::VR2D_ITERATIONS_DEF,
    parameter int DATA_WIDTH = vr2d_pkg::VR2D_DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] vec_x,
    input  logic signed [DATA_WIDTH-1:0] vec_y,
    input  logic [15:0]                  angle,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] rotated_x,
    output logic signed [DATA_WIDTH-1:0] rotated_y,
    output logic                         saturated
);
    import vr2d_pkg::*;

    localparam int XW     = DATA_WIDTH + VR2D_GUARD + 3;
    localparam int N_ITER = (ITERATIONS < VR2D_ATAN_ENTRIES) ? ITERATIONS : VR2D_ATAN_ENTRIES;
    localparam int LAT    = N_ITER + 4;
    localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                      accept;
    logic                      cv [0:N_ITER];
    logic signed [XW-1:0]      cx [0:N_ITER];
    logic signed [XW-1:0]      cy [0:N_ITER];
    logic signed [VR2D_ZW-1:0] cz [0:N_ITER];

    // fully pipelined, never back-pressures
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // fold, gain compensation and rounding
    vr2d_prescale #(
        .DATA_WIDTH (DATA_WIDTH),
        .ITERATIONS (ITERATIONS)
    ) u_prescale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .angle     (angle),
        .out_valid (cv[0]),
        .x_out     (cx[0]),
        .y_out     (cy[0]),
        .z_out     (cz[0])
    );

    // chain of cordic cells, one micro-rotation each
    genvar gi;
    generate
        for (gi = 0; gi < N_ITER; gi++)
        begin : g_cell
            vr2d_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .STAGE      (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (cv[gi]),
                .x_in      (cx[gi]),
                .y_in      (cy[gi]),
                .z_in      (cz[gi]),
                .out_valid (cv[gi+1]),
                .x_out     (cx[gi+1]),
                .y_out     (cy[gi+1]),
                .z_out     (cz[gi+1])
            );
        end
    endgenerate

    // rounding, saturation and result register
    vr2d_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv[N_ITER]),
        .x_in      (cx[N_ITER]),
        .y_in      (cy[N_ITER]),
        .out_valid (done),
        .x_out     (rotated_x),
        .y_out     (rotated_y),
        .sat_out   (saturated)
    );

`ifndef SYNTHESIS
    // every accepted transaction comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("transaction lost in pipeline");

    // no result without a matching transaction
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without transaction");

    // a saturated result sits at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (rotated_x == OUT_MAX || rotated_x == OUT_MIN ||
                                 rotated_y == OUT_MAX || rotated_y == OUT_MIN))
        else $error("saturated flag without clipped component");
`endif

endmodule

[rtl/core/vr2d_prescale.sv]
// ----------------------------------------------------------------------------
// vr2d_prescale
// Quadrant fold, gain compensation multiply and rounding into the guard format.
// ----------------------------------------------------------------------------
module vr2d_prescale #(
    parameter int DATA_WIDTH = vr2d_pkg::VR2D_DATA_WIDTH_DEF,
    parameter int ITERATIONS = vr2d_pkg::VR2D_ITERATIONS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [DATA_WIDTH-1:0]         vec_x,
    input  logic signed [DATA_WIDTH-1:0]         vec_y,
    input  logic [15:0]                          angle,
    output logic                                 out_valid,
    output logic signed [DATA_WIDTH+vr2d_pkg::VR2D_GUARD+2:0] x_out,
    output logic signed [DATA_WIDTH+vr2d_pkg::VR2D_GUARD+2:0] y_out,
    output logic signed [vr2d_pkg::VR2D_ZW-1:0]  z_out
);
    import vr2d_pkg::*;

    localparam int XW     = DATA_WIDTH + VR2D_GUARD + 3;
    localparam int NW     = DATA_WIDTH + 1;
    localparam int KW     = 33;
    localparam int PW     = NW + KW;
    localparam int RS     = VR2D_GAIN_FRAC - VR2D_GUARD;
    localparam int N_ITER = (ITERATIONS < VR2D_ATAN_ENTRIES) ? ITERATIONS : VR2D_ATAN_ENTRIES;
    localparam logic signed [KW-1:0] GAIN     = {1'b0, gain_q30(N_ITER)};
    localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (RS - 1);

    logic                     fold;
    logic [15:0]              ang_f;
    logic signed [NW-1:0]     x_ext;
    logic signed [NW-1:0]     y_ext;
    logic signed [NW-1:0]     x_fold;
    logic signed [NW-1:0]     y_fold;
    logic signed [VR2D_ZW-1:0] z_fold;

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic signed [NW-1:0]     x1_reg;
    logic signed [NW-1:0]     y1_reg;
    logic signed [VR2D_ZW-1:0] z1_reg;
    logic signed [PW-1:0]     px_reg;
    logic signed [PW-1:0]     py_reg;
    logic signed [VR2D_ZW-1:0] z2_reg;
    logic signed [XW-1:0]     x3_reg;
    logic signed [XW-1:0]     y3_reg;
    logic signed [VR2D_ZW-1:0] z3_reg;

    logic signed [PW-1:0]     px_next;
    logic signed [PW-1:0]     py_next;
    logic signed [PW-1:0]     rx_full;
    logic signed [PW-1:0]     ry_full;

    // fold angles in the left half plane onto the right half, negating the vector
    always_comb
    begin
        fold   = angle[15] ^ angle[14];
        ang_f  = fold ? {~angle[15], angle[14:0]} : angle;
        x_ext  = {vec_x[DATA_WIDTH-1], vec_x};
        y_ext  = {vec_y[DATA_WIDTH-1], vec_y};
        x_fold = fold ? -x_ext : x_ext;
        y_fold = fold ? -y_ext : y_ext;
        z_fold = {{(VR2D_ZW-32){ang_f[15]}}, ang_f, 16'h0000};
    end

    // gain multiply, then round to the guard format
    always_comb
    begin
        px_next = PW'(x1_reg) * PW'(GAIN);
        py_next = PW'(y1_reg) * PW'(GAIN);
        rx_full = (px_reg + RND_HALF) >>> RS;
        ry_full = (py_reg + RND_HALF) >>> RS;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        x1_reg <= x_fold;
        y1_reg <= y_fold;
        z1_reg <= z_fold;
        px_reg <= px_next;
        py_reg <= py_next;
        z2_reg <= z1_reg;
        x3_reg <= rx_full[XW-1:0];
        y3_reg <= ry_full[XW-1:0];
        z3_reg <= z2_reg;
    end

    assign out_valid = v3_reg;
    assign x_out     = x3_reg;
    assign y_out     = y3_reg;
    assign z_out     = z3_reg;

endmodule

[rtl/core/vr2d_cell.sv]
// ----------------------------------------------------------------------------
// vr2d_cell
// One cordic micro-rotation in rotation mode, registered.
// ----------------------------------------------------------------------------
module vr2d_cell #(
    parameter int DATA_WIDTH = vr2d_pkg::VR2D_DATA_WIDTH_DEF,
    parameter int STAGE      = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [DATA_WIDTH+vr2d_pkg::VR2D_GUARD+2:0] x_in,
    input  logic signed [DATA_WIDTH+vr2d_pkg::VR2D_GUARD+2:0] y_in,
    input  logic signed [vr2d_pkg::VR2D_ZW-1:0]  z_in,
    output logic                                 out_valid,
    output logic signed [DATA_WIDTH+vr2d_pkg::VR2D_GUARD+2:0] x_out,
    output logic signed [DATA_WIDTH+vr2d_pkg::VR2D_GUARD+2:0] y_out,
    output logic signed [vr2d_pkg::VR2D_ZW-1:0]  z_out
);
    import vr2d_pkg::*;

    localparam int XW = DATA_WIDTH + VR2D_GUARD + 3;
    localparam logic signed [VR2D_ZW-1:0] ATAN = atan_turn(STAGE);

    logic                      valid_reg;
    logic signed [XW-1:0]      x_reg;
    logic signed [XW-1:0]      y_reg;
    logic signed [VR2D_ZW-1:0] z_reg;
    logic signed [XW-1:0]      x_next;
    logic signed [XW-1:0]      y_next;
    logic signed [VR2D_ZW-1:0] z_next;
    logic signed [XW-1:0]      dx;
    logic signed [XW-1:0]      dy;

    // rotate toward zero residual angle, both updates from the old x and y
    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[VR2D_ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

[rtl/core/vr2d_post.sv]
// ----------------------------------------------------------------------------
// vr2d_post
// Drops the guard bits with rounding and clips the result to the output range.
// ----------------------------------------------------------------------------
module vr2d_post #(
    parameter int DATA_WIDTH = vr2d_pkg::VR2D_DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [DATA_WIDTH+vr2d_pkg::VR2D_GUARD+2:0] x_in,
    input  logic signed [DATA_WIDTH+vr2d_pkg::VR2D_GUARD+2:0] y_in,
    output logic                                 out_valid,
    output logic signed [DATA_WIDTH-1:0]         x_out,
    output logic signed [DATA_WIDTH-1:0]         y_out,
    output logic                                 sat_out
);
    import vr2d_pkg::*;

    localparam int XW = DATA_WIDTH + VR2D_GUARD + 3;
    localparam logic signed [XW-1:0] HALF  = XW'(1) <<< (VR2D_GUARD - 1);
    localparam logic signed [XW-1:0] MAX_V = {{(XW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] MIN_V = {{(XW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic                        valid_reg;
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic signed [DATA_WIDTH-1:0] y_reg;
    logic                        sat_reg;
    logic signed [XW-1:0]        rx;
    logic signed [XW-1:0]        ry;
    logic signed [DATA_WIDTH-1:0] x_next;
    logic signed [DATA_WIDTH-1:0] y_next;
    logic                        sat_x;
    logic                        sat_y;

    // round half up, then saturate each component
    always_comb
    begin
        rx = (x_in + HALF) >>> VR2D_GUARD;
        ry = (y_in + HALF) >>> VR2D_GUARD;
        sat_x = 1'b1;
        sat_y = 1'b1;
        if (rx > MAX_V)
            x_next = MAX_V[DATA_WIDTH-1:0];
        else if (rx < MIN_V)
            x_next = MIN_V[DATA_WIDTH-1:0];
        else
        begin
            x_next = rx[DATA_WIDTH-1:0];
            sat_x  = 1'b0;
        end
        if (ry > MAX_V)
            y_next = MAX_V[DATA_WIDTH-1:0];
        else if (ry < MIN_V)
            y_next = MIN_V[DATA_WIDTH-1:0];
        else
        begin
            y_next = ry[DATA_WIDTH-1:0];
            sat_y  = 1'b0;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        sat_reg <= sat_x | sat_y;
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign sat_out   = sat_reg;

endmodule
